// ===== hw/rtl/aaq_pkg.sv =====
// Shared types and constants for the axis-angle to quaternion pipeline.
// Holds the transaction structs, cell state structs and elaboration-time helpers.
// No dependencies.
`timescale 1ns / 1ps

package aaq_pkg;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               axis_was_zero;
  } out_item_t;

  localparam int SQRT_CELLS = 24;  // one root bit per cell, 48-bit radicand
  localparam int DIV_CELLS  = 31;  // quotient bits 30..0
  // stage numbers of the axis path, counted from the input register
  localparam int ST_IN   = 1;
  localparam int ST_SQ   = 2;
  localparam int ST_L    = 3;
  localparam int ST_SQRT_LAST = ST_L + SQRT_CELLS;
  localparam int ST_PRE  = ST_SQRT_LAST + 1;
  localparam int ST_DIV_LAST = ST_PRE + DIV_CELLS;
  localparam int ST_N    = ST_DIV_LAST + 1;
  localparam int ST_P    = ST_N + 1;
  localparam int ST_OUT  = ST_P + 1;
  localparam int LATENCY = ST_OUT;

  localparam int CW = 34;  // CORDIC datapath width, Q.30 with headroom
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef struct packed {
    logic [25:0] rem;
    logic [23:0] root;
    logic [47:0] rad;   // remaining radicand bits, consumed from the top
  } sqrt_st_t;

  typedef struct packed {
    logic [53:0]       dvs;  // divisor aligned to the current quotient bit
    logic [2:0][53:0]  rem;
    logic [2:0][30:0]  quo;
  } div_st_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_st_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] r;
    res = '0;
    b   = 64'd1 << 62;
    r   = v;
    for (int j = 0; j < 32; j++) begin
      if (b > r) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (r >= res + b) begin
          r   = r - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // shift-subtract quotient, small nonzero divisor
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], n[j]};
      if (r >= d) begin
        r    = r - d;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] cordic_gain(input int n);
    logic [63:0] p;
    p = 64'd1 << 30;
    for (int i = 0; i < 32; i++) begin
      if (i < n) p = p + (p >> (2 * i));
    end
    return p;
  endfunction

  // atan(2^-i) in Q.30 from the odd power series in Q.62
  function automatic logic [63:0] atan_q30(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    logic        stop;
    int          e;
    sum  = '0;
    stop = 1'b0;
    if (i == 0) return 64'd843314857;
    for (int k = 0; k < 32; k++) begin
      if (!stop) begin
        e = 62 - i * (2 * k + 1);
        if (e < 0) begin
          stop = 1'b1;
        end else begin
          term = udiv64(64'd1 << e, 64'(2 * k + 1));
          if (term == 0) stop = 1'b1;
          else if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
      end
    end
    return (sum + (64'd1 << 31)) >> 32;
  endfunction

endpackage

// ===== hw/rtl/aaq_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root: one root bit per cycle.
// Depends on aaq_pkg.
`timescale 1ns / 1ps

module aaq_sqrt_cell
  import aaq_pkg::*;
(
  input  logic     clk_i,
  input  sqrt_st_t st_i,
  output sqrt_st_t st_o
);

  sqrt_st_t st_d, st_q;
  logic [25:0] rem_sh;
  logic [25:0] trial;

  always_comb begin
    rem_sh = {st_i.rem[23:0], st_i.rad[47:46]};
    trial  = {st_i.root[23:0], 2'b01};
    st_d.rad = {st_i.rad[45:0], 2'b00};
    if (rem_sh >= trial) begin
      st_d.rem  = rem_sh - trial;
      st_d.root = {st_i.root[22:0], 1'b1};
    end else begin
      st_d.rem  = rem_sh;
      st_d.root = {st_i.root[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

// ===== hw/rtl/aaq_div_cell.sv =====
// One restoring-division cell: one quotient bit for each of the three lanes.
// Depends on aaq_pkg.
`timescale 1ns / 1ps

module aaq_div_cell
  import aaq_pkg::*;
(
  input  logic    clk_i,
  input  div_st_t st_i,
  output div_st_t st_o
);

  div_st_t st_d, st_q;

  always_comb begin
    st_d.dvs = st_i.dvs >> 1;
    for (int k = 0; k < 3; k++) begin
      if (st_i.rem[k] >= st_i.dvs) begin
        st_d.rem[k] = st_i.rem[k] - st_i.dvs;
        st_d.quo[k] = {st_i.quo[k][29:0], 1'b1};
      end else begin
        st_d.rem[k] = st_i.rem[k];
        st_d.quo[k] = {st_i.quo[k][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

// ===== hw/rtl/aaq_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation, registered.
// Depends on aaq_pkg.
`timescale 1ns / 1ps

module aaq_cordic_cell
  import aaq_pkg::*;
#(
  parameter int SHIFT = 0,
  parameter logic signed [CW-1:0] ATAN = '0
) (
  input  logic       clk_i,
  input  cordic_st_t st_i,
  output cordic_st_t st_o
);

  cordic_st_t st_d, st_q;
  logic signed [CW-1:0] dx, dy;

  always_comb begin
    dx = $signed(st_i.y) >>> SHIFT;
    dy = $signed(st_i.x) >>> SHIFT;
    if (!st_i.z[CW-1]) begin
      st_d.x = st_i.x - dx;
      st_d.y = st_i.y + dy;
      st_d.z = st_i.z - ATAN;
    end else begin
      st_d.x = st_i.x + dx;
      st_d.y = st_i.y - dy;
      st_d.z = st_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

// ===== hw/rtl/axis_angle_to_quaternion.sv =====
// Axis-angle to unit quaternion, fully pipelined top level.
// Depends on aaq_pkg, aaq_sqrt_cell, aaq_div_cell, aaq_cordic_cell.
//
// Usage:
//   Drive item_i and pulse start_i; a transaction is taken on every edge with
//   start_i high and busy_o low. busy_o is always low: one transaction per cycle.
//   Each result appears on result_o for exactly one cycle with done_o high,
//   in the order the transactions were taken.
//   The latency is set by the axis path: 24 square-root cells (one root bit
//   each), 31 division cells (one quotient bit each) and the input register,
//   square, length, divider setup, unit axis, multiply and rounding stages.
//   The CORDIC chain for the half angle runs alongside and is shorter, so
//   CORDIC_STAGES does not change the latency.
//   Reset clears only the valid chain; no results come out until new
//   transactions have travelled through. The receiver cannot stall, so no
//   result is held back.
`timescale 1ns / 1ps

module axis_angle_to_quaternion
  import aaq_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_item_t  item_i,
  output logic      done_o,
  output out_item_t result_o
);

  localparam int ST_RED = ST_N - CORDIC_STAGES;
  localparam logic [63:0] GAIN_P   = cordic_gain(CORDIC_STAGES);
  localparam logic [63:0] GAIN_R   = isqrt64(GAIN_P << 30);
  localparam logic [63:0] CORDIC_K = ((64'd1 << 60) + GAIN_R / 2) / GAIN_R;

  logic vld_q [ST_IN:ST_OUT];
  in_item_t in_q;

  logic [2:0][30:0] sq_q;
  logic [31:0]      len_q;
  logic [2:0][15:0] mag_q [ST_SQ:ST_SQRT_LAST];
  logic [2:0]       sgn_q [ST_SQ:ST_DIV_LAST];
  logic             zero_q [ST_L:ST_P];
  logic [2:0]       ovf_q [ST_PRE:ST_DIV_LAST];

  sqrt_st_t sq_chain [0:SQRT_CELLS];
  div_st_t  div_head_q;
  div_st_t  div_chain [0:DIV_CELLS];

  logic signed [15:0] ang_q [ST_SQ:ST_RED-1];
  cordic_st_t cor_head_q;
  cordic_st_t cor_chain [0:CORDIC_STAGES];
  logic       neg_q [ST_RED:ST_N];

  logic [2:0][31:0] n_q;
  logic [2:0][63:0] prod_q;
  logic [31:0]      cs_q;
  out_item_t        result_q;

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = ST_IN; k <= ST_OUT; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[ST_IN] <= start_i;
      for (int k = ST_IN + 1; k <= ST_OUT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  assign busy_o = 1'b0;

  // ---------------- squares, length, side lines ----------------
  logic [2:0][15:0] mag_d;
  logic [2:0]       sgn_d;
  logic [2:0][31:0] sqw;

  always_comb begin
    sqw[0] = $signed(in_q.axis_x) * $signed(in_q.axis_x);
    sqw[1] = $signed(in_q.axis_y) * $signed(in_q.axis_y);
    sqw[2] = $signed(in_q.axis_z) * $signed(in_q.axis_z);
    sgn_d  = {in_q.axis_z[15], in_q.axis_y[15], in_q.axis_x[15]};
    mag_d[0] = in_q.axis_x[15] ? 16'(~in_q.axis_x + 16'd1) : in_q.axis_x;
    mag_d[1] = in_q.axis_y[15] ? 16'(~in_q.axis_y + 16'd1) : in_q.axis_y;
    mag_d[2] = in_q.axis_z[15] ? 16'(~in_q.axis_z + 16'd1) : in_q.axis_z;
  end

  always_ff @(posedge clk_i) begin
    in_q <= item_i;
    for (int k = 0; k < 3; k++) sq_q[k] <= sqw[k][30:0];
    len_q <= {1'b0, sq_q[0]} + {1'b0, sq_q[1]} + {1'b0, sq_q[2]};
    mag_q[ST_SQ] <= mag_d;
    for (int k = ST_SQ + 1; k <= ST_SQRT_LAST; k++) mag_q[k] <= mag_q[k-1];
    sgn_q[ST_SQ] <= sgn_d;
    for (int k = ST_SQ + 1; k <= ST_DIV_LAST; k++) sgn_q[k] <= sgn_q[k-1];
    zero_q[ST_L] <= (sq_q == '0);
    for (int k = ST_L + 1; k <= ST_P; k++) zero_q[k] <= zero_q[k-1];
  end

  // ---------------- square root of length * 2^16 ----------------
  assign sq_chain[0] = '{rem: '0, root: '0, rad: {len_q, 16'h0000}};

  for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
    aaq_sqrt_cell u_cell (
      .clk_i (clk_i),
      .st_i  (sq_chain[g]),
      .st_o  (sq_chain[g+1])
    );
  end

  // ---------------- divider setup: rounded numerator, overflow check ----------------
  logic [23:0]      root;
  logic [2:0][53:0] num;
  logic [2:0]       ovf_d;

  always_comb begin
    root = sq_chain[SQRT_CELLS].root;
    for (int k = 0; k < 3; k++) begin
      num[k]   = {mag_q[ST_SQRT_LAST][k], 38'h0} + 54'(root >> 1);
      ovf_d[k] = ({1'b0, num[k]} >= {root, 31'h0});
    end
  end

  always_ff @(posedge clk_i) begin
    div_head_q.dvs <= {root, 30'h0};
    div_head_q.rem <= num;
    div_head_q.quo <= '0;
    ovf_q[ST_PRE] <= ovf_d;
    for (int k = ST_PRE + 1; k <= ST_DIV_LAST; k++) ovf_q[k] <= ovf_q[k-1];
  end

  assign div_chain[0] = div_head_q;

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    aaq_div_cell u_cell (
      .clk_i (clk_i),
      .st_i  (div_chain[g]),
      .st_o  (div_chain[g+1])
    );
  end

  // ---------------- half angle reduction and CORDIC ----------------
  logic signed [CW-1:0] half_ang;
  logic signed [CW-1:0] z_init;
  logic                 neg_d;

  always_comb begin
    half_ang = {ang_q[ST_RED-1][15], ang_q[ST_RED-1], 17'h0};
    neg_d    = 1'b0;
    z_init   = half_ang;
    if (half_ang > HALF_PI_Q30) begin
      z_init = half_ang - PI_Q30;
      neg_d  = 1'b1;
    end else if (half_ang < -HALF_PI_Q30) begin
      z_init = half_ang + PI_Q30;
      neg_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q[ST_SQ] <= in_q.angle;
    for (int k = ST_SQ + 1; k <= ST_RED - 1; k++) ang_q[k] <= ang_q[k-1];
    cor_head_q.x <= CW'(CORDIC_K);
    cor_head_q.y <= '0;
    cor_head_q.z <= z_init;
    neg_q[ST_RED] <= neg_d;
    for (int k = ST_RED + 1; k <= ST_N; k++) neg_q[k] <= neg_q[k-1];
  end

  assign cor_chain[0] = cor_head_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    aaq_cordic_cell #(
      .SHIFT (g),
      .ATAN  (CW'(atan_q30(g)))
    ) u_cell (
      .clk_i (clk_i),
      .st_i  (cor_chain[g]),
      .st_o  (cor_chain[g+1])
    );
  end

  // ---------------- unit axis, multiply, rounding ----------------
  logic [2:0][31:0]     n_d;
  logic [30:0]          nmag;
  logic signed [CW-1:0] sn_w, cs_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nmag = div_chain[DIV_CELLS].quo[k];
      if (ovf_q[ST_DIV_LAST][k] || nmag > 31'h4000_0000) nmag = 31'h4000_0000;
      n_d[k] = sgn_q[ST_DIV_LAST][k] ? 32'(-{1'b0, nmag}) : {1'b0, nmag};
    end
    sn_w = neg_q[ST_N] ? -cor_chain[CORDIC_STAGES].y : cor_chain[CORDIC_STAGES].y;
    cs_w = neg_q[ST_N] ? -cor_chain[CORDIC_STAGES].x : cor_chain[CORDIC_STAGES].x;
  end

  function automatic logic [15:0] round_q46(input logic [63:0] p);
    logic [63:0] m;
    logic [17:0] q;
    m = p[63] ? 64'(~p + 64'd1) : p;
    q = 18'((m + (64'd1 << 45)) >> 46);
    if (q > 18'd16384) q = 18'd16384;
    return p[63] ? 16'(-q[15:0]) : q[15:0];
  endfunction

  function automatic logic [15:0] round_q16(input logic [31:0] c);
    logic [31:0] m;
    logic [16:0] q;
    m = c[31] ? 32'(~c + 32'd1) : c;
    q = 17'((m + 32'd32768) >> 16);
    if (q > 17'd16384) q = 17'd16384;
    return c[31] ? 16'(-q[15:0]) : q[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= $signed(n_q[k]) * $signed(sn_w[31:0]);
    end
    cs_q <= cs_w[31:0];
    if (zero_q[ST_P]) begin
      result_q <= '{quat_x: '0, quat_y: '0, quat_z: '0, quat_w: '0, axis_was_zero: 1'b1};
    end else begin
      result_q.quat_x        <= round_q46(prod_q[0]);
      result_q.quat_y        <= round_q46(prod_q[1]);
      result_q.quat_z        <= round_q46(prod_q[2]);
      result_q.quat_w        <= round_q16(cs_q);
      result_q.axis_was_zero <= 1'b0;
    end
  end

  assign done_o   = vld_q[ST_OUT];
  assign result_o = result_q;

endmodule

// ===== hw/rtl/aaq_checker.sv =====
// Port-level checks for axis_angle_to_quaternion, attached by bind.
// Depends on aaq_pkg and the top level's ports.
`timescale 1ns / 1ps

module aaq_checker
  import aaq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input in_item_t  item_i,
  input logic      done_o,
  input out_item_t result_o
);

  logic took;
  assign took = start_i && !busy_o;

  // every transaction gives one result after the fixed latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    took |-> ##LATENCY done_o)
    else $error("result missing after accepted transaction");

  // no result without a transaction the latency before
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(took, LATENCY))
    else $error("result without a transaction");

  // a zero axis in gives the zero flag and an all-zero quaternion out
  a_zero_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (took && item_i.axis_x == '0 && item_i.axis_y == '0 && item_i.axis_z == '0)
      |-> ##LATENCY (result_o.axis_was_zero && result_o.quat_x == '0 &&
                     result_o.quat_y == '0 && result_o.quat_z == '0 &&
                     result_o.quat_w == '0))
    else $error("zero axis not flagged");

  // results stay within +-1.0 in Q1.14
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(result_o.quat_x) >= -16'sd16384 &&
                $signed(result_o.quat_x) <= 16'sd16384 &&
                $signed(result_o.quat_y) >= -16'sd16384 &&
                $signed(result_o.quat_y) <= 16'sd16384 &&
                $signed(result_o.quat_z) >= -16'sd16384 &&
                $signed(result_o.quat_z) <= 16'sd16384 &&
                $signed(result_o.quat_w) >= -16'sd16384 &&
                $signed(result_o.quat_w) <= 16'sd16384))
    else $error("result component out of range");

endmodule

bind axis_angle_to_quaternion aaq_checker u_aaq_checker (.*);
